>>> rtl/core/srec_pkg.sv
// Shared types, character codes and helper functions for the S-record to
// Intel HEX converter. No dependencies; every file but srec_if imports this one.
package srec_pkg;

    // Line and request status codes reported in a status beat.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_FORMAT = 3'd2,
        ST_UNIMPL = 3'd3,
        ST_XSUM   = 3'd4,
        ST_HALTED = 3'd5,
        ST_BUSY   = 3'd6
    } t_status;

    // Request codes on the input channel.
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_PULL = 1'b1;

    // ASCII characters the converter recognizes or produces.
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_S     = 8'h53;
    localparam logic [7:0] C_ONE   = 8'h31;
    localparam logic [7:0] C_NINE  = 8'h39;
    localparam logic [7:0] C_COLON = 8'h3A;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_F     = 8'h46;

    localparam logic [9:0]  POS_MAX        = 10'd1023;
    localparam logic [9:0]  MIN_LINE_LEN   = 10'd10;
    localparam logic [7:0]  MIN_COUNT      = 8'd3;
    localparam logic [15:0] OFFSET_RESET   = 16'hE000;
    localparam logic [3:0]  EOF_LAST_POS   = 4'd11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       feed;
        logic [7:0] feed_char;
        logic       cr_set;
        logic       cr_clr;
        logic       end_line;
        logic       emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       halted;
        logic       out_pending;
        logic       pending_cr;
        t_status    end_status;
        logic [7:0] out_char;
        logic       out_last;
    } t_dp_stat;

    // One result beat.
    typedef struct packed {
        logic       is_status;
        t_status    status;
        logic [7:0] out_char;
        logic       char_valid;
        logic       last_of_record;
    } t_result;

    // Hex digit value; bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    // Uppercase ASCII digit for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] c;
        c = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
        return c;
    endfunction

    // Characters of the end-of-file record ":00000001FF" before its LF.
    function automatic logic [7:0] eof_char(input logic [3:0] p);
        logic [7:0] c;
        unique case (p)
            4'd0:    c = C_COLON;
            4'd8:    c = C_ONE;
            4'd9,
            4'd10:   c = C_F;
            default: c = C_ZERO;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/srec_if.sv
// Valid/ready channel interfaces for the converter's request and result beats.
// Depends on nothing; the top level uses both.
interface srec_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] in_char;

    modport source(output valid, output operation, output in_char, input ready);
    modport sink(input valid, input operation, input in_char, output ready);
endinterface

interface srec_out_if;
    logic       valid;
    logic       ready;
    logic       is_status;
    logic [2:0] status;
    logic [7:0] out_char;
    logic       char_valid;
    logic       last_of_record;

    modport source(output valid, output is_status, output status, output out_char,
                   output char_valid, output last_of_record, input ready);
    modport sink(input valid, input is_status, input status, input out_char,
                 input char_valid, input last_of_record, output ready);
endinterface

>>> rtl/core/srec_dp.sv
// Datapath of the converter: line parser, checksum, data memory and the
// Intel HEX character generator. Depends on srec_pkg.
module srec_dp #(
    parameter int DATA_BYTES = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  srec_pkg::t_cmd    i_cmd,
    output srec_pkg::t_dp_stat o_stat
);
    import srec_pkg::*;

    localparam int AW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
    localparam logic [8:0] MAX_N = 9'(DATA_BYTES);

    logic [15:0] r_offset;
    logic [9:0]  r_char_pos, n_char_pos;
    logic [7:0]  r_rec_type, n_rec_type;
    logic [7:0]  r_byte_count, n_byte_count;
    logic [15:0] r_load_addr, n_load_addr;
    logic [7:0]  r_sum, n_sum;
    logic [3:0]  r_hi, n_hi;
    t_status     r_line_err, n_line_err;
    logic        r_pending_cr, n_pending_cr;
    logic        r_halted, n_halted;
    logic        r_out_pending, n_out_pending;
    logic [9:0]  r_out_pos, n_out_pos;
    logic [7:0]  r_out_sum, n_out_sum;

    logic [7:0]    mem [DATA_BYTES];
    logic [7:0]    r_rd_data;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;

    t_status     end_st;
    logic [7:0]  gen_char;
    logic        gen_last;

    // Status a line would end with, lowest position first.
    always_comb begin
        logic [9:0] need;
        need = {1'b0, r_byte_count, 1'b0};
        if (r_char_pos < MIN_LINE_LEN) end_st = ST_SHORT;
        else if (r_line_err != ST_OK) end_st = r_line_err;
        else if (r_rec_type == C_ONE && r_char_pos < need + 10'd2) end_st = ST_FORMAT;
        else if (r_rec_type == C_ONE && r_char_pos < need + 10'd4) end_st = ST_XSUM;
        else end_st = ST_OK;
    end

    // Memory read follows the output position; the read data is registered.
    assign mem_raddr = AW'((r_out_pos - 10'd9) >> 1);

    // Next output character of the pending record.
    always_comb begin
        logic       has_data;
        logic [7:0] n;
        logic [7:0] cs;
        logic [9:0] p;
        logic [9:0] data_end;
        p         = r_out_pos;
        has_data  = (r_rec_type == C_ONE) && (r_byte_count > MIN_COUNT);
        n         = r_byte_count - MIN_COUNT;
        data_end  = 10'd9 + {1'b0, n, 1'b0};
        cs        = 8'd0 - r_out_sum;
        gen_last  = 1'b0;
        n_out_sum = r_out_sum;
        if (!has_data) begin
            if (p >= {6'd0, EOF_LAST_POS}) begin
                gen_char = C_LF;
                gen_last = 1'b1;
            end else begin
                gen_char = eof_char(p[3:0]);
            end
        end else if (p == 10'd0) begin
            gen_char = C_COLON;
        end else if (p == 10'd1) begin
            gen_char = hex_digit(n[7:4]);
        end else if (p == 10'd2) begin
            n_out_sum = r_out_sum + n;
            gen_char  = hex_digit(n[3:0]);
        end else if (p == 10'd3) begin
            gen_char = hex_digit(r_load_addr[15:12]);
        end else if (p == 10'd4) begin
            n_out_sum = r_out_sum + r_load_addr[15:8];
            gen_char  = hex_digit(r_load_addr[11:8]);
        end else if (p == 10'd5) begin
            gen_char = hex_digit(r_load_addr[7:4]);
        end else if (p == 10'd6) begin
            n_out_sum = r_out_sum + r_load_addr[7:0];
            gen_char  = hex_digit(r_load_addr[3:0]);
        end else if (p < 10'd9) begin
            gen_char = C_ZERO;
        end else if (p < data_end) begin
            if (!p[0]) begin
                n_out_sum = r_out_sum + r_rd_data;
                gen_char  = hex_digit(r_rd_data[3:0]);
            end else begin
                gen_char = hex_digit(r_rd_data[7:4]);
            end
        end else if (p == data_end) begin
            gen_char = hex_digit(cs[7:4]);
        end else if (p == data_end + 10'd1) begin
            gen_char = hex_digit(cs[3:0]);
        end else begin
            gen_char = C_LF;
            gen_last = 1'b1;
        end
    end

    // Next state of the line parser and output generator.
    always_comb begin
        logic [9:0] p;
        logic [4:0] hv;
        logic [7:0] b;
        logic [7:0] n;
        logic [9:0] data_end;
        logic [7:0] c;
        c            = i_cmd.feed_char;
        p            = r_char_pos;
        hv           = hex_value(c);
        b            = {r_hi, hv[3:0]};
        n            = r_byte_count - MIN_COUNT;
        data_end     = 10'd8 + {1'b0, n, 1'b0};
        n_char_pos   = r_char_pos;
        n_rec_type   = r_rec_type;
        n_byte_count = r_byte_count;
        n_load_addr  = r_load_addr;
        n_sum        = r_sum;
        n_hi         = r_hi;
        n_line_err   = r_line_err;
        n_pending_cr = r_pending_cr;
        n_halted     = r_halted;
        n_out_pending = r_out_pending;
        n_out_pos    = r_out_pos;
        mem_we       = 1'b0;
        mem_waddr    = AW'((p - 10'd8) >> 1);
        mem_wdata    = b;

        if (i_cmd.cr_set) n_pending_cr = 1'b1;
        if (i_cmd.cr_clr) n_pending_cr = 1'b0;

        // One line character.
        if (i_cmd.feed) begin
            if (p < POS_MAX) n_char_pos = p + 10'd1;
            if (r_line_err == ST_OK) begin
                if (p == 10'd0) begin
                    if (c != C_S) n_line_err = ST_FORMAT;
                end else if (p == 10'd1) begin
                    n_rec_type = c;
                    if (c != C_ONE && c != C_NINE) n_line_err = ST_UNIMPL;
                end else if (p < 10'd8) begin
                    if (hv[4]) begin
                        n_line_err = ST_FORMAT;
                    end else if (!p[0]) begin
                        n_hi = hv[3:0];
                    end else begin
                        n_sum = r_sum + b;
                        if (p == 10'd3) begin
                            n_byte_count = b;
                            if (b < MIN_COUNT) n_line_err = ST_FORMAT;
                            else if (r_rec_type == C_ONE && {1'b0, b - MIN_COUNT} > MAX_N)
                                n_line_err = ST_FORMAT;
                        end else if (p == 10'd5) begin
                            n_load_addr[15:8] = b;
                        end else begin
                            n_load_addr[7:0] = b;
                        end
                    end
                end else if (r_rec_type == C_ONE && r_byte_count >= MIN_COUNT) begin
                    if (p < data_end) begin
                        if (hv[4]) begin
                            n_line_err = ST_FORMAT;
                        end else if (!p[0]) begin
                            n_hi = hv[3:0];
                        end else begin
                            n_sum  = r_sum + b;
                            mem_we = 1'b1;
                        end
                    end else if (p == data_end) begin
                        if (hv[4]) n_line_err = ST_XSUM;
                        else n_hi = hv[3:0];
                    end else if (p == data_end + 10'd1) begin
                        if (hv[4] || ~r_sum != b) n_line_err = ST_XSUM;
                    end
                end
            end
        end

        // End of line: publish the record or halt.
        if (i_cmd.end_line) begin
            if (end_st == ST_OK) begin
                if (r_rec_type == C_ONE) n_load_addr = r_load_addr - r_offset;
                n_out_pending = 1'b1;
                n_out_pos     = 10'd0;
            end else begin
                n_halted = 1'b1;
            end
            n_char_pos   = 10'd0;
            n_line_err   = ST_OK;
            n_sum        = 8'd0;
            n_hi         = 4'd0;
            n_pending_cr = 1'b0;
        end

        // One output character leaves.
        if (i_cmd.emit) begin
            n_out_pos = r_out_pos + 10'd1;
            if (gen_last) n_out_pending = 1'b0;
        end
    end

    // Parser, generator and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset      <= OFFSET_RESET;
            r_char_pos    <= '0;
            r_rec_type    <= '0;
            r_byte_count  <= '0;
            r_load_addr   <= '0;
            r_sum         <= '0;
            r_hi          <= '0;
            r_line_err    <= ST_OK;
            r_pending_cr  <= 1'b0;
            r_halted      <= 1'b0;
            r_out_pending <= 1'b0;
            r_out_pos     <= '0;
            r_out_sum     <= '0;
        end else begin
            if (i_cfg_we) r_offset <= i_cfg_data;
            r_char_pos    <= n_char_pos;
            r_rec_type    <= n_rec_type;
            r_byte_count  <= n_byte_count;
            r_load_addr   <= n_load_addr;
            r_sum         <= n_sum;
            r_hi          <= n_hi;
            r_line_err    <= n_line_err;
            r_pending_cr  <= n_pending_cr;
            r_halted      <= n_halted;
            r_out_pending <= n_out_pending;
            r_out_pos     <= n_out_pos;
            if (i_cmd.end_line) r_out_sum <= 8'd0;
            else if (i_cmd.emit) r_out_sum <= n_out_sum;
        end
    end

    // Data byte memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        r_rd_data <= mem[mem_raddr];
    end

    assign o_stat.halted      = r_halted;
    assign o_stat.out_pending = r_out_pending;
    assign o_stat.pending_cr  = r_pending_cr;
    assign o_stat.end_status  = end_st;
    assign o_stat.out_char    = gen_char;
    assign o_stat.out_last    = gen_last;

endmodule

>>> rtl/core/srec_ctrl.sv
// Controller of the converter: request decode, sequencing and the result
// beat register. Depends on srec_pkg.
module srec_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_operation,
    input  logic [7:0]          i_in_char,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output srec_pkg::t_result   o_result,
    output srec_pkg::t_cmd      o_cmd,
    input  srec_pkg::t_dp_stat  i_stat
);
    import srec_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED2,
        S_PULL
    } t_state;

    t_state     r_state;
    logic [7:0] r_held;
    logic       r_out_valid;
    t_result    r_out;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept     = i_in_valid && o_in_ready;

    // Datapath commands for the current cycle.
    always_comb begin
        o_cmd           = '0;
        o_cmd.feed_char = i_in_char;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_operation == OP_FEED && !i_stat.halted
                    && !i_stat.out_pending) begin
                    if (i_in_char == C_LF) begin
                        o_cmd.end_line = 1'b1;
                    end else if (i_stat.pending_cr) begin
                        // The held CR turns out to be an ordinary character.
                        o_cmd.feed      = 1'b1;
                        o_cmd.feed_char = C_CR;
                        o_cmd.cr_clr    = (i_in_char != C_CR);
                    end else if (i_in_char == C_CR) begin
                        o_cmd.cr_set = 1'b1;
                    end else begin
                        o_cmd.feed = 1'b1;
                    end
                end
            end
            S_FEED2: begin
                o_cmd.feed      = 1'b1;
                o_cmd.feed_char = r_held;
            end
            S_PULL: begin
                o_cmd.emit = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    // State and result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_out       <= '0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out  <= '0;
                        r_held <= i_in_char;
                        if (i_operation == OP_PULL) begin
                            if (i_stat.out_pending) begin
                                r_state <= S_PULL;
                            end else begin
                                r_out_valid <= 1'b1;
                            end
                        end else if (i_stat.halted) begin
                            r_out_valid      <= 1'b1;
                            r_out.is_status  <= 1'b1;
                            r_out.status     <= ST_HALTED;
                        end else if (i_stat.out_pending) begin
                            r_out_valid      <= 1'b1;
                            r_out.is_status  <= 1'b1;
                            r_out.status     <= ST_BUSY;
                        end else if (i_in_char == C_LF) begin
                            r_out_valid      <= 1'b1;
                            r_out.is_status  <= 1'b1;
                            r_out.status     <= i_stat.end_status;
                        end else if (i_stat.pending_cr && i_in_char != C_CR) begin
                            r_state <= S_FEED2;
                        end
                    end
                end
                S_FEED2: begin
                    r_state <= S_IDLE;
                end
                S_PULL: begin
                    r_out_valid          <= 1'b1;
                    r_out.is_status      <= 1'b0;
                    r_out.status         <= ST_OK;
                    r_out.out_char       <= i_stat.out_char;
                    r_out.char_valid     <= 1'b1;
                    r_out.last_of_record <= i_stat.out_last;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

>>> rtl/core/srecord_to_intel_hex_unit.sv
// Top level of the S-record to Intel HEX converter.
// Depends on srec_pkg, srec_if, srec_ctrl and srec_dp.
//
// Requests arrive as beats on i_in: operation 0 feeds one S-record character,
// operation 1 pulls the next Intel HEX character. Results leave as beats on
// o_out, at most one per request. A feed of LF returns the line status; a
// feed while halted or while a record is pending returns halted or busy;
// other feeds return nothing. A pull always returns one beat, with
// char_valid 0 when no record is pending.
// Timing: an ordinary feed reaches the datapath in the cycle it is accepted;
// a feed that releases a held CR feeds the CR, then its own character in
// S_FEED2. A status beat appears in the cycle after its request; a pulled
// character passes S_PULL, which waits for the registered read of the data
// byte memory, then the result register. A new request is taken only once
// the previous result beat has left, so ordinary feeds go one per cycle.
// Reset clears all control state, sets address_offset to 0xE000 and leaves
// the data memory unwritten. When the receiver stalls, the result beat holds
// and i_in.ready stays low until it is taken. The user writes address_offset
// via i_cfg_we / i_cfg_data only while idle; the block does not enforce it.
module srecord_to_intel_hex_unit #(
    parameter int DATA_BYTES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srec_in_if.sink     i_in,
    srec_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import srec_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;
    t_result  result;
    logic     out_valid;

    // Sequencing and result register.
    srec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_operation (i_in.operation),
        .i_in_char   (i_in.in_char),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_result    (result),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Parser, memory and character generator.
    srec_dp #(
        .DATA_BYTES (DATA_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat)
    );

    assign o_out.valid          = out_valid;
    assign o_out.is_status      = result.is_status;
    assign o_out.status         = result.status;
    assign o_out.out_char       = result.out_char;
    assign o_out.char_valid     = result.char_valid;
    assign o_out.last_of_record = result.last_of_record;

    // A request is never taken while a result beat waits.
    a_ready_only_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !o_out.valid)
        else $error("request taken while a result beat waits");

    // A status beat carries no character.
    a_status_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_status) |-> (!o_out.char_valid && o_out.out_char == 8'd0))
        else $error("status beat carries a character");

    // The end of a record is a valid LF character.
    a_last_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_of_record) |-> (o_out.char_valid && o_out.out_char == C_LF))
        else $error("record end is not a valid LF");

endmodule

>>> test/srec_checker.sv
// Scoreboard for the S-record to Intel HEX converter: predicts every result beat.
// Depends on srec_pkg and the srec_in_if / srec_out_if channel interfaces.
module srec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srec_in_if          i_in,
    srec_out_if         i_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output int          o_outstanding,
    output int          o_errors
);
    import srec_pkg::*;

    // Converter state as the predictor tracks it.
    logic [15:0] offset;
    logic [7:0]  store [256];
    logic [9:0]  line_pos;
    logic [7:0]  rec_kind;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  line_sum;
    logic [3:0]  nib_hi;
    t_status     line_err;
    logic        held_cr;
    logic        stopped;
    logic        rec_ready;
    logic [9:0]  emit_pos;
    logic [7:0]  emit_sum;

    t_result expected_q[$];
    int      fails;

    assign o_outstanding = expected_q.size();
    assign o_errors      = fails;

    function automatic logic [4:0] digit_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return 5'(c - "0");
        if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
        if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
        return 5'h10;
    endfunction

    function automatic logic [7:0] upper_digit(logic [3:0] n);
        return (n < 10) ? 8'("0" + n) : 8'("A" + n - 10);
    endfunction

    function automatic void flag(t_status e);
        if (line_err == ST_OK) line_err = e;
    endfunction

    // Absorb one character of the current line.
    function automatic void absorb(logic [7:0] c);
        logic [9:0] p;
        logic [4:0] hv;
        logic [7:0] b;
        logic [9:0] data_end;
        p  = line_pos;
        hv = digit_value(c);
        if (line_pos < 10'd1023) line_pos++;
        if (line_err != ST_OK) return;
        if (p == 0) begin
            if (c != C_S) flag(ST_FORMAT);
            return;
        end
        if (p == 1) begin
            rec_kind = c;
            if (c != C_ONE && c != C_NINE) flag(ST_UNIMPL);
            return;
        end
        if (p < 8) begin
            if (hv[4]) begin
                flag(ST_FORMAT);
                return;
            end
            if (!p[0]) begin
                nib_hi = hv[3:0];
                return;
            end
            b = {nib_hi, hv[3:0]};
            line_sum += b;
            if (p == 3) begin
                count = b;
                if (b < 3) flag(ST_FORMAT);
            end else if (p == 5) begin
                addr[15:8] = b;
            end else begin
                addr[7:0] = b;
            end
            return;
        end
        if (rec_kind != C_ONE || count < 3) return;
        data_end = 10'(8 + 2 * (count - 3));
        if (p < data_end) begin
            if (hv[4]) begin
                flag(ST_FORMAT);
                return;
            end
            if (!p[0]) begin
                nib_hi = hv[3:0];
                return;
            end
            b = {nib_hi, hv[3:0]};
            line_sum += b;
            store[(p - 8) / 2] = b;
        end else if (p == data_end) begin
            if (hv[4]) flag(ST_XSUM);
            else nib_hi = hv[3:0];
        end else if (p == data_end + 1) begin
            if (hv[4]) flag(ST_XSUM);
            else if (~line_sum != {nib_hi, hv[3:0]}) flag(ST_XSUM);
        end
    endfunction

    // Close the line on LF and return its status.
    function automatic t_status close_line();
        t_status st;
        int      len;
        len = line_pos;
        if (len < 10) st = ST_SHORT;
        else if (line_err != ST_OK) st = line_err;
        else if (rec_kind == C_ONE && len < 2 * count + 2) st = ST_FORMAT;
        else if (rec_kind == C_ONE && len < 2 * count + 4) st = ST_XSUM;
        else st = ST_OK;
        if (st == ST_OK) begin
            if (rec_kind == C_ONE) addr = addr - offset;
            rec_ready = 1'b1;
            emit_pos  = 0;
            emit_sum  = 0;
        end else begin
            stopped = 1'b1;
        end
        line_pos = 0;
        line_err = ST_OK;
        line_sum = 0;
        nib_hi   = 0;
        held_cr  = 1'b0;
        return st;
    endfunction

    // Next character of the pending Intel HEX record.
    function automatic logic [7:0] emit_char(output logic last);
        int         p, n, k;
        logic [7:0] v, cs;
        p = emit_pos;
        last = 1'b0;
        emit_pos++;
        if (!(rec_kind == C_ONE && count > 3)) begin
            if (p >= 11) begin
                last = 1'b1;
                rec_ready = 1'b0;
                return C_LF;
            end
            case (p)
                0:       return C_COLON;
                8:       return C_ONE;
                9, 10:   return C_F;
                default: return C_ZERO;
            endcase
        end
        n = count - 3;
        case (p)
            0: return C_COLON;
            1: return upper_digit(4'(n >> 4));
            2: begin
                emit_sum += 8'(n);
                return upper_digit(4'(n));
            end
            3: return upper_digit(addr[15:12]);
            4: begin
                emit_sum += addr[15:8];
                return upper_digit(addr[11:8]);
            end
            5: return upper_digit(addr[7:4]);
            6: begin
                emit_sum += addr[7:0];
                return upper_digit(addr[3:0]);
            end
            7, 8: return C_ZERO;
            default: ;
        endcase
        if (p < 9 + 2 * n) begin
            k = (p - 9) / 2;
            v = store[k];
            if (((p - 9) % 2) == 0) return upper_digit(v[7:4]);
            emit_sum += v;
            return upper_digit(v[3:0]);
        end
        cs = 8'h00 - emit_sum;
        if (p == 9 + 2 * n) return upper_digit(cs[7:4]);
        if (p == 10 + 2 * n) return upper_digit(cs[3:0]);
        last = 1'b1;
        rec_ready = 1'b0;
        return C_LF;
    endfunction

    // Work out the result of one accepted request, if any.
    function automatic void predict_request(logic op, logic [7:0] c);
        t_result r;
        logic    last;
        r = '0;
        if (op == OP_PULL) begin
            if (rec_ready) begin
                r.out_char       = emit_char(last);
                r.char_valid     = 1'b1;
                r.last_of_record = last;
            end
            expected_q.push_back(r);
            return;
        end
        r.is_status = 1'b1;
        if (stopped) r.status = ST_HALTED;
        else if (rec_ready) r.status = ST_BUSY;
        else if (c == C_LF) r.status = close_line();
        else begin
            if (held_cr) begin
                held_cr = 1'b0;
                absorb(C_CR);
            end
            if (c == C_CR) held_cr = 1'b1;
            else absorb(c);
            return;
        end
        expected_q.push_back(r);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        fails++;
    endtask

    initial fails = 0;

    // Compare the result beat first: it always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_result w;
        if (!i_rst_n) begin
            offset    = OFFSET_RESET;
            line_pos  = 0;
            rec_kind  = 0;
            count     = 0;
            addr      = 0;
            line_sum  = 0;
            nib_hi    = 0;
            line_err  = ST_OK;
            held_cr   = 1'b0;
            stopped   = 1'b0;
            rec_ready = 1'b0;
            emit_pos  = 0;
            emit_sum  = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected beat, status", i_out.status, 0);
                end else begin
                    w = expected_q.pop_front();
                    if (i_out.is_status != w.is_status)
                        report("is_status", i_out.is_status, w.is_status);
                    if (i_out.status != w.status)
                        report("status", i_out.status, w.status);
                    if (i_out.out_char != w.out_char)
                        report("out_char", i_out.out_char, w.out_char);
                    if (i_out.char_valid != w.char_valid)
                        report("char_valid", i_out.char_valid, w.char_valid);
                    if (i_out.last_of_record != w.last_of_record)
                        report("last_of_record", i_out.last_of_record, w.last_of_record);
                end
            end
            if (i_in.valid && i_in.ready) predict_request(i_in.operation, i_in.in_char);
            if (i_cfg_we) offset = i_cfg_data;
        end
    end
endmodule

>>> test/tb_srecord_to_intel_hex_unit.sv
// Stimulus and verdict for the S-record to Intel HEX converter.
// Depends on srec_pkg, the channel interfaces, the converter and srec_checker.
module tb_srecord_to_intel_hex_unit;
    import srec_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    int          outstanding;
    int          errors;
    int          sent;
    int          send_idle;
    int          recv_stall;
    int          quiet;

    srec_in_if  in_ch ();
    srec_out_if out_ch ();

    srecord_to_intel_hex_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    srec_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The receiver stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("srecord_to_intel_hex_unit regression: fail");
            $finish;
        end
    end

    logic [7:0] line_q[$];

    // Send one request beat, with random idle cycles before it.
    task automatic send(logic op, logic [7:0] c);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.in_char   <= c;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        // Pick the idling phase from the progress of the run.
        case ((sent / 110) % 5)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 73; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 73; end
            3: begin send_idle = 10; recv_stall = 10; end
            default: begin send_idle = 0; recv_stall = 0; end
        endcase
    endtask

    // Pause until every expected beat has come and the block has settled.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_offset(logic [15:0] v);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic put_hex(logic [7:0] b, bit lower);
        logic [3:0] n;
        for (int i = 1; i >= 0; i--) begin
            n = b[i*4 +: 4];
            if (n < 10) line_q.push_back(8'("0" + n));
            else line_q.push_back(lower ? 8'("a" + n - 10) : 8'("A" + n - 10));
        end
    endtask

    // Build an S1 line (or S9) with n data bytes and its checksum.
    task automatic build_line(bit s9, int n, logic [15:0] a, bit fill_ff, bit lower);
        logic [7:0] sum, b;
        line_q.delete();
        line_q.push_back(C_S);
        line_q.push_back(s9 ? C_NINE : C_ONE);
        sum = 8'(n + 3) + a[15:8] + a[7:0];
        put_hex(8'(n + 3), lower);
        put_hex(a[15:8], lower);
        put_hex(a[7:0], lower);
        for (int i = 0; i < n; i++) begin
            b = fill_ff ? 8'hFF : 8'($urandom_range(255));
            sum += b;
            put_hex(b, lower);
        end
        put_hex(~sum, lower);
    endtask

    // Feed the built line, end it, then pull its record back.
    task automatic run_line(bit s9, int n);
        int len;
        foreach (line_q[i]) send(OP_FEED, line_q[i]);
        // Trailing characters past the checksum are ignored, CR among them.
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                logic [7:0] junk;
                junk = 8'($urandom_range(255));
                if (junk == C_LF) junk = C_CR;
                send(OP_FEED, junk);
            end
        end
        if ($urandom_range(1)) send(OP_FEED, C_CR);
        send(OP_FEED, C_LF);
        if ($urandom_range(3) == 0) send(OP_FEED, 8'($urandom_range(255)));
        len = (s9 || n == 0) ? 12 : 13 + 2 * n;
        repeat (len) send(OP_PULL, 8'($urandom_range(255)));
        if ($urandom_range(3) == 0) send(OP_PULL, 8'($urandom_range(255)));
    endtask

    initial begin
        int kind, n;
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        in_ch.valid     = 1'b0;
        in_ch.operation = OP_FEED;
        in_ch.in_char   = '0;
        out_ch.ready    = 1'b0;
        quiet           = 0;
        sent            = 0;
        send_idle       = 0;
        recv_stall      = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: pull with nothing pending, empty S1, S9, extreme fields.
        send(OP_PULL, 8'hFF);
        build_line(1'b0, 0, 16'h0000, 1'b0, 1'b0);
        run_line(1'b0, 0);
        build_line(1'b1, 0, 16'hFFFF, 1'b0, 1'b1);
        run_line(1'b1, 0);
        build_line(1'b0, 2, 16'hFFFF, 1'b1, 1'b0);
        run_line(1'b0, 2);
        set_offset(16'h0000);
        build_line(1'b0, 1, 16'h0000, 1'b1, 1'b1);
        run_line(1'b0, 1);
        set_offset(16'hFFFF);
        build_line(1'b0, 1, 16'h1234, 1'b0, 1'b0);
        run_line(1'b0, 1);

        // Random part: good lines only, with offset changes between them.
        while (sent < 550) begin
            if ($urandom_range(5) == 0) set_offset(16'($urandom_range(65535)));
            kind = $urandom_range(9);
            n = (kind == 0) ? $urandom_range(60, 20) : $urandom_range(12);
            build_line(kind == 1, n, 16'($urandom_range(65535)), 1'b0, 1'($urandom_range(1)));
            run_line(kind == 1, n);
        end

        // One broken line at the end, since any error halts until reset.
        drain();
        build_line(1'b0, 3, 16'($urandom_range(65535)), 1'b0, 1'b0);
        case ($urandom_range(5))
            0: line_q = line_q[0:4];
            1: line_q[0] = "X";
            2: line_q[1] = "5";
            3: line_q[9] = "G";
            4: line_q[line_q.size() - 1] = (line_q[line_q.size() - 1] == "0") ? "1" : "0";
            default: begin
                line_q[2] = "0";
                line_q[3] = "2";
            end
        endcase
        foreach (line_q[i]) send(OP_FEED, line_q[i]);
        send(OP_FEED, C_LF);
        send(OP_FEED, "S");
        send(OP_FEED, C_LF);
        send(OP_PULL, 8'h00);
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0) $display("srecord_to_intel_hex_unit regression: pass");
        else $display("srecord_to_intel_hex_unit regression: fail");
        $finish;
    end
endmodule
